@@ design/packed_bitmap_pixel_writer_assert.svh @@
// Assertion macros shared by the pixel writer RTL.
`ifndef PACKED_BITMAP_PIXEL_WRITER_ASSERT_SVH
`define PACKED_BITMAP_PIXEL_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBPW_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pixel writer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PBPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pixel writer assertion failed");

`endif

@@ design/pbpw_pkg.sv @@
// Types, codes and constants shared by the packed bitmap pixel writer.
`timescale 1ns / 1ps
`default_nettype none

package pbpw_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_PLOT  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Draw modes.
  localparam logic [1:0] DRAW_SET   = 2'd0;
  localparam logic [1:0] DRAW_FLIP  = 2'd1;
  localparam logic [1:0] DRAW_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_DRAW_MODE   = 3'd0;
  localparam logic [2:0] REG_PIXELS_PB   = 3'd1;
  localparam logic [2:0] REG_REVERSE     = 3'd2;
  localparam logic [2:0] REG_BYTES_PL    = 3'd3;
  localparam logic [2:0] REG_TOTAL_BYTES = 3'd4;
  localparam logic [2:0] REG_FILL_VALUE  = 3'd5;

  // Width of a computed plot address: 15-bit row times 13-bit pitch plus a byte column.
  localparam int PLOT_ADDR_W = 29;
  // Fraction bits of the reciprocal used for column / pixels_per_byte.
  localparam int QUOT_SHIFT  = 18;

  typedef logic [PLOT_ADDR_W-1:0] plot_addr_t;

  // One bit per pixel position inside a byte.
  localparam logic [7:0] BIT_MASK [8] = '{8'o001, 8'o002, 8'o004, 8'o010,
                                          8'o020, 8'o040, 8'o100, 8'o200};

  typedef struct packed {
    logic [1:0]  draw_mode;
    logic [3:0]  pixels_per_byte;
    logic        reverse_bits;
    logic [12:0] bytes_per_line;
    logic [16:0] total_bytes;
    logic [7:0]  fill_value;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div;
    logic check;
    logic ram_re;
    logic rmw_we;
    logic clear_start;
    logic clear_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       oor;
    logic       clear_done;
  } dp_status_t;

  // floor(2^QUOT_SHIFT / ppb) for an effective ppb of 1 to 8.
  function automatic logic [18:0] ppb_recip(input logic [3:0] ppb);
    logic [18:0] r;
    case (ppb)
      4'd1:    r = 19'd262144;
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87381;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd52428;
      4'd6:    r = 19'd43690;
      4'd7:    r = 19'd37449;
      default: r = 19'd32768;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/packed_bitmap_pixel_writer.sv @@
// The controller takes one beat at a time and walks each plot or read beat through multiply,
// quotient correction, check, store read, store write (plot only) and result load; a beat out
// of range skips the store read and write, and the result load waits while the output stalls.
// A clear beat fills min(total_bytes, STORE_BYTES) store bytes, one store byte written per cycle.
// Reset (rst_ni, asynchronous, active low) idles the controller, empties the output
// register and loads the register defaults; the frame store is undefined until cleared.
`timescale 1ns / 1ps
`default_nettype none

module packed_bitmap_pixel_writer #(
  parameter int STORE_BYTES = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port, APB style.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [14:0] column_i,
  input  wire logic [14:0] row_index_i,
  input  wire logic [15:0] byte_address_i,
  // Output channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic             out_of_range_o
);

  // The register bank lives here. Registers sit at byte address 4*index; the
  // two low address bits are ignored and indexes past the last register are
  // dropped on write and read back as zero.
  pbpw_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_index;
  logic           reg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (reg_write) begin
      case (reg_index)
        pbpw_pkg::REG_DRAW_MODE:   cfg_d.draw_mode       = pwdata[1:0];
        pbpw_pkg::REG_PIXELS_PB:   cfg_d.pixels_per_byte = pwdata[3:0];
        pbpw_pkg::REG_REVERSE:     cfg_d.reverse_bits    = pwdata[0];
        pbpw_pkg::REG_BYTES_PL:    cfg_d.bytes_per_line  = pwdata[12:0];
        pbpw_pkg::REG_TOTAL_BYTES: cfg_d.total_bytes     = pwdata[16:0];
        pbpw_pkg::REG_FILL_VALUE:  cfg_d.fill_value      = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.draw_mode       <= pbpw_pkg::DRAW_SET;
      cfg_q.pixels_per_byte <= 4'd8;
      cfg_q.reverse_bits    <= 1'b0;
      cfg_q.bytes_per_line  <= 13'd80;
      cfg_q.total_bytes     <= 17'd65536;
      cfg_q.fill_value      <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back returns the stored field, zero-extended; written bits beyond the field are not kept.
  always_comb begin
    case (reg_index)
      pbpw_pkg::REG_DRAW_MODE:   prdata = 32'(cfg_q.draw_mode);
      pbpw_pkg::REG_PIXELS_PB:   prdata = 32'(cfg_q.pixels_per_byte);
      pbpw_pkg::REG_REVERSE:     prdata = 32'(cfg_q.reverse_bits);
      pbpw_pkg::REG_BYTES_PL:    prdata = 32'(cfg_q.bytes_per_line);
      pbpw_pkg::REG_TOTAL_BYTES: prdata = 32'(cfg_q.total_bytes);
      pbpw_pkg::REG_FILL_VALUE:  prdata = 32'(cfg_q.fill_value);
      default:                   prdata = 32'd0;
    endcase
  end

  // The controller steps each plot or read beat through multiply, quotient correction,
  // address check, store read and store write (plot only); the datapath holds every
  // intermediate value and the result register, so a finished result can
  // wait for the consumer while the next input beat is taken.
  pbpw_pkg::ctrl_cmd_t  cmd;
  pbpw_pkg::dp_status_t status;

  pbpw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pbpw_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .kind_i         (kind_i),
    .column_i       (column_i),
    .row_index_i    (row_index_i),
    .byte_address_i (byte_address_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .read_data_o    (read_data_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

`default_nettype wire

@@ design/pbpw_ram.sv @@
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module pbpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/pbpw_datapath.sv @@
// Datapath: address arithmetic, read-modify-write, clear pointer and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_bitmap_pixel_writer_assert.svh"

module pbpw_datapath #(
  parameter int STORE_BYTES = 65536
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pbpw_pkg::cfg_t        cfg_i,
  input  wire logic [1:0]            kind_i,
  input  wire logic [14:0]           column_i,
  input  wire logic [14:0]           row_index_i,
  input  wire logic [15:0]           byte_address_i,
  input  wire pbpw_pkg::ctrl_cmd_t   cmd_i,
  output pbpw_pkg::dp_status_t       status_o,
  output logic [7:0]                 read_data_o,
  output logic                       out_of_range_o
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int LW = (AW + 1 > 17) ? AW + 1 : 17;

  // Captured item.
  logic [1:0]  kind_q;
  logic [14:0] col_q;
  logic [14:0] row_q;
  logic [15:0] baddr_q;

  // Pipeline registers of the address computation.
  logic [27:0] rowprod_q;
  logic [33:0] qprod_q;
  logic [14:0] quot_q;
  logic [2:0]  pos_q;
  pbpw_pkg::plot_addr_t addr_q;
  logic        oor_q;
  logic [7:0]  mask_q;

  logic [LW-1:0] ptr_q, ptr_d;
  logic [7:0]    read_data_q;
  logic          oor_out_q;

  // Effective configuration values.
  logic [3:0]    ppb_eff;
  logic [LW-1:0] limit;
  logic [LW-1:0] total_ext;

  always_comb begin
    if (cfg_i.pixels_per_byte == 4'd0) begin
      ppb_eff = 4'd1;
    end else if (cfg_i.pixels_per_byte > 4'd8) begin
      ppb_eff = 4'd8;
    end else begin
      ppb_eff = cfg_i.pixels_per_byte;
    end
  end

  assign total_ext = LW'(cfg_i.total_bytes);
  assign limit     = (total_ext > LW'(STORE_BYTES)) ? LW'(STORE_BYTES) : total_ext;

  // Products.
  logic [27:0] rowprod_d;
  logic [33:0] qprod_d;
  assign rowprod_d = row_q * cfg_i.bytes_per_line;
  assign qprod_d   = col_q * pbpw_pkg::ppb_recip(ppb_eff);

  // Quotient correction: the estimate is low by at most one.
  logic [14:0] q0;
  logic [18:0] qmul;
  logic [18:0] rem_w;
  logic [4:0]  r0;
  logic        fix;
  logic [4:0]  r1;
  logic [3:0]  pos_rev;
  logic [2:0]  pos_d;
  logic [14:0] quot_d;

  assign q0     = qprod_q[pbpw_pkg::QUOT_SHIFT+14:pbpw_pkg::QUOT_SHIFT];
  assign qmul   = 19'(q0) * 19'(ppb_eff);
  assign rem_w  = 19'(col_q) - qmul;
  assign r0     = rem_w[4:0];
  assign fix    = (r0 >= {1'b0, ppb_eff});
  assign r1     = fix ? (r0 - {1'b0, ppb_eff}) : r0;
  assign quot_d = fix ? (q0 + 15'd1) : q0;
  assign pos_rev = ppb_eff - 4'd1 - r1[3:0];
  assign pos_d  = cfg_i.reverse_bits ? pos_rev[2:0] : r1[2:0];

  // Address and range check.
  pbpw_pkg::plot_addr_t addr_d;
  always_comb begin
    if (kind_q == pbpw_pkg::KIND_READ) begin
      addr_d = pbpw_pkg::plot_addr_t'(baddr_q);
    end else begin
      addr_d = pbpw_pkg::plot_addr_t'(rowprod_q) + pbpw_pkg::plot_addr_t'(quot_q);
    end
  end

  // Modify step.
  logic [7:0] ram_rdata;
  logic [7:0] new_byte;
  always_comb begin
    case (cfg_i.draw_mode)
      pbpw_pkg::DRAW_SET:   new_byte = ram_rdata | mask_q;
      pbpw_pkg::DRAW_FLIP:  new_byte = ram_rdata ^ mask_q;
      pbpw_pkg::DRAW_CLEAR: new_byte = ram_rdata & ~mask_q;
      default:              new_byte = ram_rdata;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      col_q   <= column_i;
      row_q   <= row_index_i;
      baddr_q <= byte_address_i;
    end
    if (cmd_i.mul) begin
      rowprod_q <= rowprod_d;
      qprod_q   <= qprod_d;
    end
    if (cmd_i.div) begin
      quot_q <= quot_d;
      pos_q  <= pos_d;
    end
    if (cmd_i.check) begin
      addr_q <= addr_d;
      oor_q  <= (addr_d >= pbpw_pkg::plot_addr_t'(limit));
      mask_q <= pbpw_pkg::BIT_MASK[pos_q];
    end
    if (cmd_i.load_out) begin
      read_data_q <= (kind_q == pbpw_pkg::KIND_READ && !oor_q) ? ram_rdata : 8'd0;
      oor_out_q   <= oor_q && (kind_q == pbpw_pkg::KIND_PLOT ||
                               kind_q == pbpw_pkg::KIND_READ);
    end
  end

  // Clear pointer: counts bytes filled by the current clear.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.clear_start) begin
      ptr_d = '0;
    end else if (cmd_i.clear_step) begin
      ptr_d = ptr_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // Frame store port.
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  assign ram_addr  = cmd_i.clear_step ? ptr_q[AW-1:0] : addr_q[AW-1:0];
  assign ram_wdata = cmd_i.clear_step ? cfg_i.fill_value : new_byte;

  pbpw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear_step | cmd_i.rmw_we),
    .re_i    (cmd_i.ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign status_o.kind       = kind_q;
  assign status_o.oor        = oor_q;
  assign status_o.clear_done = (ptr_q >= limit);

  assign read_data_o    = read_data_q;
  assign out_of_range_o = oor_out_q;

  `PBPW_ASSERT_IMPL(a_clear_in_bounds, clk_i, rst_ni, cmd_i.clear_step, ptr_q < limit)

endmodule

`default_nettype wire

@@ design/pbpw_ctrl.sv @@
// Controller state machine sequencing one item at a time.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_bitmap_pixel_writer_assert.svh"

module pbpw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire pbpw_pkg::dp_status_t status_i,
  output pbpw_pkg::ctrl_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.kind == pbpw_pkg::KIND_CLEAR) begin
          cmd_o.clear_start = 1'b1;
          state_d           = S_CLEAR;
        end else if (status_i.kind == pbpw_pkg::KIND_PLOT ||
                     status_i.kind == pbpw_pkg::KIND_READ) begin
          state_d = S_READ;
        end else begin
          state_d = S_RESP;
        end
      end
      S_READ: begin
        if (status_i.oor) begin
          state_d = S_RESP;
        end else begin
          cmd_o.ram_re = 1'b1;
          state_d      = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.rmw_we = (status_i.kind == pbpw_pkg::KIND_PLOT);
        state_d      = S_RESP;
      end
      S_CLEAR: begin
        if (status_i.clear_done) begin
          state_d = S_RESP;
        end else begin
          cmd_o.clear_step = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `PBPW_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `PBPW_ASSERT_IMPL(a_write_states, clk_i, rst_ni, cmd_o.rmw_we || cmd_o.clear_step, state_q == S_WRITE || state_q == S_CLEAR)
  `PBPW_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out, !out_valid_q || out_ready_i)

endmodule

`default_nettype wire
